// ===== rtl/core/lpht_pkg.sv =====
// Shared constants and types for the linear probing hash table core.
package lpht_pkg;

  localparam int KEY_W           = 32;
  localparam int STATUS_W        = 2;
  localparam int SLOT_W          = 4;
  localparam int ENTRY_W         = KEY_W + 1;
  localparam int DEF_TABLE_SLOTS = 16;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

endpackage

// ===== rtl/core/linear_probe_hash_table_core.sv =====
// Top level of the open-addressing hash table with linear probing.
//
// Command channel: an operation is taken at a rising edge with start high and
// busy low; mode selects insert or search, key is the 32-bit key.
// Result channel: done is high for exactly one cycle with status and slot;
// the receiver cannot stall, so results are never held back.
// Each transfer computes the home slot (key mod TABLE_SLOTS) in a registered
// remainder unit (reciprocal multiply, then a low-bit fix-up), then probes
// the slot RAM at one entry a cycle (one read port, registered read data).
// An operation makes 1 to TABLE_SLOTS probes; done is raised as the core
// returns to idle, so a new command can be taken while done is still shown,
// but none is taken while an operation is under way.
// Keys and valid bits share one RAM entry. After reset a clearing pass
// empties every slot in turn; busy stays high during it.
// Duplicate keys are stored again; search returns the first copy met.
module linear_probe_hash_table_core #(
  parameter int TABLE_SLOTS = lpht_pkg::DEF_TABLE_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [lpht_pkg::KEY_W-1:0]    key,
  output logic                          done,
  output logic [lpht_pkg::STATUS_W-1:0] status,
  output logic [lpht_pkg::SLOT_W-1:0]   slot
);
  import lpht_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE
  } state_t;

  state_t           state;
  logic [SW-1:0]    pos;
  logic [SW-1:0]    cnt;
  logic             op_mode;
  logic [KEY_W-1:0] op_key;

  logic [SW-1:0]      pos_inc;
  logic               pos_last;
  logic               cnt_last;
  logic               mod_start;
  logic               mod_done;
  logic [SW-1:0]      mod_rem;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [SW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               ent_valid;
  logic               ent_match;
  logic               probe_end;
  status_t            probe_status;
  logic               probe_hit;

  assign busy      = (state != S_IDLE);
  assign mod_start = (state == S_IDLE) && start;
  assign pos_last  = (pos == SW'(TABLE_SLOTS - 1));
  assign pos_inc   = pos_last ? '0 : pos + 1'b1;
  assign cnt_last  = (cnt == SW'(TABLE_SLOTS - 1));
  assign ent_valid = ram_rdata[KEY_W];
  assign ent_match = ram_rdata[KEY_W-1:0] == op_key;
  assign ram_raddr = (state == S_HASH) ? mod_rem : pos_inc;

  lpht_mod #(
    .DIVISOR (TABLE_SLOTS)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (key),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  lpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    probe_end    = 1'b0;
    probe_hit    = 1'b0;
    probe_status = ST_MISSING;
    if (op_mode == MODE_INSERT) begin
      if (!ent_valid) begin
        probe_end    = 1'b1;
        probe_hit    = 1'b1;
        probe_status = ST_INSERTED;
      end else if (cnt_last) begin
        probe_end    = 1'b1;
        probe_status = ST_FULL;
      end
    end else begin
      if (!ent_valid) begin
        probe_end    = 1'b1;
        probe_status = ST_MISSING;
      end else if (ent_match) begin
        probe_end    = 1'b1;
        probe_hit    = 1'b1;
        probe_status = ST_FOUND;
      end else if (cnt_last) begin
        probe_end    = 1'b1;
        probe_status = ST_MISSING;
      end
    end
  end

  assign ram_we = (state == S_CLEAR) ||
                  ((state == S_PROBE) && (op_mode == MODE_INSERT) && !ent_valid);
  assign ram_wdata = (state == S_CLEAR) ? '0 : {1'b1, op_key};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pos   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          pos <= pos_inc;
          if (pos_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_mode <= mode;
            op_key  <= key;
            state   <= S_HASH;
          end
        end
        S_HASH: begin
          if (mod_done) begin
            pos   <= mod_rem;
            cnt   <= '0;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (probe_end) begin
            done   <= 1'b1;
            status <= probe_status;
            slot   <= probe_hit ? SLOT_W'(pos) : '0;
            state  <= S_IDLE;
          end else begin
            pos <= pos_inc;
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_after_probe: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_PROBE)
    else $error("result strobe without a probe");

  a_slot_zero_on_miss: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FULL || status == ST_MISSING) |-> slot == '0)
    else $error("nonzero slot on full or missing");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_HASH) |-> !ram_we)
    else $error("table write outside probe or clear");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("busy not raised after accepted transfer");

  a_insert_writes_on_done: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_INSERTED |-> $past(ram_we))
    else $error("insert reported without a table write");
`endif

endmodule

// ===== rtl/core/lpht_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lpht_mod.sv =====
// Remainder of a key by the table size, by reciprocal multiplication and a registered low-bit fix-up.
module lpht_mod #(
  parameter int DIVISOR = lpht_pkg::DEF_TABLE_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lpht_pkg::KEY_W-1:0] dividend,
  output logic                       done,
  output logic [$clog2(DIVISOR)-1:0] rem
);
  import lpht_pkg::*;

  localparam int RW = $clog2(DIVISOR);
  localparam int PW = 2 * KEY_W + 1;
  localparam logic [KEY_W:0] RECIP =
    (KEY_W+1)'(((64'd1 << (KEY_W + RW)) / DIVISOR) + 1);
  localparam logic [RW-1:0] DIV_LO = RW'(DIVISOR);

  logic          run;
  logic [RW-1:0] key_lo;
  logic [RW-1:0] quo_lo;
  logic [PW-1:0] prod;

  // quotient = (key * RECIP) >> (KEY_W + RW); only its low bits are needed
  assign prod = PW'(dividend) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      run  <= start;
      if (start) begin
        key_lo <= dividend[RW-1:0];
        quo_lo <= prod[KEY_W+RW +: RW];
      end
      if (run) begin
        rem  <= key_lo - RW'(quo_lo * DIV_LO);
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== dv/linear_probe_hash_table_core_tb.sv =====
// Testbench for linear_probe_hash_table_core: directed and random insert/search checking.
module linear_probe_hash_table_core_tb;
  import lpht_pkg::*;

  localparam int NUM_SLOTS   = DEF_TABLE_SLOTS;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
  } hash_result_t;

  logic              clk   = 1'b0;
  logic              rst   = 1'b1;
  logic              start = 1'b0;
  logic              mode  = MODE_INSERT;
  logic [KEY_W-1:0]  key   = '0;
  logic              busy;
  logic              done;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  logic [KEY_W-1:0]  bucket_key  [NUM_SLOTS];
  logic              bucket_used [NUM_SLOTS];
  hash_result_t      pending_results[$];
  logic [KEY_W-1:0]  inserted_keys[$];
  int                mismatches = 0;
  int                cycles = 0;
  bit                idle_on = 1'b1;

  linear_probe_hash_table_core #(.TABLE_SLOTS(NUM_SLOTS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .mode   (mode),
    .key    (key),
    .done   (done),
    .status (status),
    .slot   (slot)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Probe model: home = key mod slots, walk forward with wrap.
  function automatic hash_result_t predict_op(input logic m, input logic [KEY_W-1:0] k);
    hash_result_t r;
    int pos;
    r.status = (m == MODE_INSERT) ? ST_FULL : ST_MISSING;
    r.slot   = '0;
    pos = int'(k % NUM_SLOTS);
    for (int n = 0; n < NUM_SLOTS; n++) begin
      if (m == MODE_INSERT) begin
        if (!bucket_used[pos]) begin
          bucket_key[pos]  = k;
          bucket_used[pos] = 1'b1;
          r.status = ST_INSERTED;
          r.slot   = pos[SLOT_W-1:0];
          return r;
        end
      end else begin
        if (!bucket_used[pos]) return r;
        if (bucket_key[pos] == k) begin
          r.status = ST_FOUND;
          r.slot   = pos[SLOT_W-1:0];
          return r;
        end
      end
      pos = (pos + 1 == NUM_SLOTS) ? 0 : pos + 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    hash_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d slot=%0d", status, slot));
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.status)
          report_mismatch($sformatf("status %0d, want %0d", status, exp_r.status));
        if (slot !== exp_r.slot)
          report_mismatch($sformatf("slot %0d, want %0d", slot, exp_r.slot));
      end
    end
  end

  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_op(input logic m, input logic [KEY_W-1:0] k);
    hash_result_t r;
    start <= 1'b1;
    mode  <= m;
    key   <= k;
    do @(posedge clk); while (!(start && !busy));
    r = predict_op(m, k);
    pending_results.push_back(r);
    if (m == MODE_INSERT && r.status == ST_INSERTED) inserted_keys.push_back(k);
    maybe_idle();
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int sel;
    sel = $urandom_range(0, 9);
    k = $urandom;
    if (sel < 4 && inserted_keys.size() != 0) begin
      k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
    end else if (sel < 7) begin
      k[3:0] = 4'($urandom_range(0, 3));
    end else if (sel == 7) begin
      case ($urandom_range(0, 3))
        0: k = '0;
        1: k = '1;
        2: k = 32'h8000_0000;
        default: k = 32'h7FFF_FFFF;
      endcase
    end
    return k;
  endfunction

  task automatic test_basic();
    send_op(MODE_SEARCH, 32'h0000_0000);
    send_op(MODE_SEARCH, 32'hFFFF_FFFF);
    send_op(MODE_INSERT, 32'h0000_0000);
    send_op(MODE_INSERT, 32'hFFFF_FFFF);
    send_op(MODE_INSERT, 32'h0000_0010);
    send_op(MODE_INSERT, 32'h0000_0000);
    send_op(MODE_INSERT, 32'hFFFF_FFEF);
    send_op(MODE_SEARCH, 32'h0000_0000);
    send_op(MODE_SEARCH, 32'hFFFF_FFEF);
    send_op(MODE_SEARCH, 32'h0000_0020);
    send_op(MODE_SEARCH, 32'hAAAA_AAAA);
    send_op(MODE_SEARCH, 32'h5555_5555);
  endtask

  // Search-heavy traffic while the table fills slowly.
  task automatic test_random_fill(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) send_op(MODE_INSERT, pick_key());
      else send_op(MODE_SEARCH, pick_key());
    end
  endtask

  task automatic test_full_table();
    int free_slots;
    free_slots = 0;
    foreach (bucket_used[i]) if (!bucket_used[i]) free_slots++;
    repeat (free_slots) send_op(MODE_INSERT, pick_key());
    send_op(MODE_INSERT, 32'h0000_0005);
    send_op(MODE_SEARCH, 32'h0000_0025);
    send_op(MODE_SEARCH, 32'h0000_0010);
    send_op(MODE_SEARCH, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      send_op($urandom_range(0, 1) ? MODE_SEARCH : MODE_INSERT, pick_key());
    end
  endtask

  initial begin
    foreach (bucket_used[i]) begin
      bucket_used[i] = 1'b0;
      bucket_key[i]  = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_basic();
    drain();
    test_random_fill(300);
    drain();
    test_full_table();
    test_random_mix(150);
    drain();
    idle_on = 1'b0;
    test_random_mix(100);
    drain();
    repeat (NUM_SLOTS + 12) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
